>>> design/lgrs_pkg.sv
// Shared types and constants for the Game of Life row stream.
package lgrs_pkg;

  localparam int MaxCols = 64;
  localparam int ColW    = 7;

  localparam logic [ColW-1:0] ColsReset = ColW'(MaxCols);

  // Bits one column cell shows its neighbours.
  typedef struct packed {
    logic above;
    logic centre;
    logic down;
  } col_bits_t;

  // Per-item command to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [MaxCols-1:0] cells;
    logic               done;
  } res_entry_t;

  // Up to two result items pushed at once, packed from the front.
  typedef struct packed {
    logic [1:0] cnt;
    res_entry_t first;
    res_entry_t second;
  } res_push_t;

endpackage

>>> design/lgrs_cell.sv
// One column cell: holds the column's above and centre bits, applies B3/S23.
module lgrs_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lgrs_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   down_i,
  input  logic                   active_i,
  input  logic                   interior_i,
  input  lgrs_pkg::col_bits_t    left_i,
  input  lgrs_pkg::col_bits_t    right_i,
  output lgrs_pkg::col_bits_t    self_o,
  output logic                   next_o
);

  logic       above_q, above_d;
  logic       centre_q, centre_d;
  logic [3:0] nbr_cnt;
  logic       rule_bit;

  always_comb begin
    above_d  = above_q;
    centre_d = centre_q;
    if (ctrl_i.clear) begin
      above_d  = 1'b0;
      centre_d = 1'b0;
    end else if (ctrl_i.shift) begin
      above_d  = centre_q;
      centre_d = down_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q  <= 1'b0;
      centre_q <= 1'b0;
    end else begin
      above_q  <= above_d;
      centre_q <= centre_d;
    end
  end

  assign self_o = '{above: above_q, centre: centre_q, down: down_i};

  assign nbr_cnt = 4'(left_i.above) + 4'(left_i.centre) + 4'(left_i.down)
                 + 4'(right_i.above) + 4'(right_i.centre) + 4'(right_i.down)
                 + 4'(above_q) + 4'(down_i);

  assign rule_bit = (nbr_cnt == 4'd3) || (centre_q && (nbr_cnt == 4'd2));

  // inactive columns read zero, border columns pass the centre bit
  assign next_o = active_i & (interior_i ? rule_bit : centre_q);

endmodule

>>> design/lgrs_out_queue.sv
// Three-entry shifting result queue, takes up to two items per cycle while room_o is high.
module lgrs_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lgrs_pkg::res_push_t   push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output lgrs_pkg::res_entry_t  head_o
);

  logic [1:0]           cnt_q, cnt_d, cnt_after;
  logic                 pop;
  lgrs_pkg::res_entry_t ent_q [3];
  lgrs_pkg::res_entry_t ent_d [3];

  assign pop       = (cnt_q != 2'd0) && ready_i;
  assign cnt_after = cnt_q - 2'(pop);
  assign room_o    = (cnt_after <= 2'd1);

  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
    if (push_i.cnt != 2'd0) begin
      case (cnt_after)
        2'd0: begin
          ent_d[0] = push_i.first;
          ent_d[1] = push_i.second;
        end
        2'd1: begin
          ent_d[1] = push_i.first;
          ent_d[2] = push_i.second;
        end
        default: begin
          ent_d[2] = push_i.first;
        end
      endcase
    end
    cnt_d = cnt_after + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[0];

endmodule

>>> design/life_generation_row_stream.sv
// Top level: Game of Life B3/S23 generation over a stream of grid rows.
//
// A frame arrives as rows on the input channel (row_valid_i/row_ready_o),
// one 64-bit row per item, the final row flagged by is_last_row_i. Results
// leave on res_valid_o/res_ready_i as next-generation rows, frame_done_o
// set on the frame's final row.
// The first row of a frame comes out at once as border. Each row after
// the second lets the held centre row be evolved and emitted; the last row then also
// comes out unchanged with frame_done_o, and the row store clears.
// A row of 64 column cells holds the above and centre rows; each cell
// swaps bits with its two neighbours and evaluates its column in the
// cycle the row is taken; the results are registered. Throughput: one
// row per cycle while the queue has room. An item yields up to two
// results, which go into a three-entry queue; the input is taken
// whenever at most one result stays queued after this cycle's pop, so a
// stalled receiver backs up the input after at most three pending results.
// cols_in_use (cfg_we_i/cfg_wdata_i) sets the active width; values above
// 64 act as 64. Reset empties the row store and queue, width becomes 64.
module life_generation_row_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lgrs_pkg::ColW-1:0]       cfg_wdata_i,
  input  logic                            row_valid_i,
  output logic                            row_ready_o,
  input  logic [lgrs_pkg::MaxCols-1:0]    row_cells_i,
  input  logic                            is_last_row_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [lgrs_pkg::MaxCols-1:0]    next_row_cells_o,
  output logic                            frame_done_o
);

  localparam int N = lgrs_pkg::MaxCols;
  localparam int W = lgrs_pkg::ColW;

  logic [W-1:0]          cols_q, cols_d;
  logic [W-1:0]          ncols;
  logic [1:0]            seen_q, seen_d;
  logic                  accept;
  logic [N-1:0]          active_m, interior_m;
  logic [N-1:0]          row_m;
  logic [N-1:0]          evolved;
  lgrs_pkg::col_bits_t   cbits [N];
  lgrs_pkg::cell_ctrl_t  ctrl;
  lgrs_pkg::res_entry_t  e0, e1, head;
  logic                  e0_v, e1_v;
  lgrs_pkg::res_push_t   push;
  logic                  room;

  // config register
  assign cols_d = cfg_we_i ? cfg_wdata_i : cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= lgrs_pkg::ColsReset;
    end else begin
      cols_q <= cols_d;
    end
  end

  assign ncols = (cols_q > W'(N)) ? W'(N) : cols_q;

  // per-column masks; column 0 and column ncols-1 are border
  for (genvar j = 0; j < N; j++) begin : g_mask
    assign active_m[j]   = (W'(j) < ncols);
    assign interior_m[j] = (j != 0) && ((W'(j) + W'(1)) < ncols);
  end

  assign row_m  = row_cells_i & active_m;
  assign accept = row_valid_i && row_ready_o;

  // frame sequencing
  always_comb begin
    seen_d     = seen_q;
    ctrl.shift = 1'b0;
    ctrl.clear = 1'b0;
    if (accept) begin
      if (is_last_row_i) begin
        ctrl.clear = 1'b1;
        seen_d     = 2'd0;
      end else begin
        ctrl.shift = 1'b1;
        seen_d     = (seen_q == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // the cell row; edge cells see dead neighbours beyond the grid
  for (genvar j = 0; j < N; j++) begin : g_cell
    lgrs_pkg::col_bits_t lft, rgt;
    if (j == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_ln
      assign lft = cbits[j-1];
    end
    if (j == N-1) begin : g_r0
      assign rgt = '0;
    end else begin : g_rn
      assign rgt = cbits[j+1];
    end
    lgrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .down_i     (row_m[j]),
      .active_i   (active_m[j]),
      .interior_i (interior_m[j]),
      .left_i     (lft),
      .right_i    (rgt),
      .self_o     (cbits[j]),
      .next_o     (evolved[j])
    );
  end

  // results of this item: evolved centre (or first row), then the last row
  assign e0_v = (seen_q == 2'd0) || (seen_q == 2'd2);
  assign e1_v = (seen_q != 2'd0) && is_last_row_i;
  assign e0   = (seen_q == 2'd0)
              ? lgrs_pkg::res_entry_t'{cells: row_m, done: is_last_row_i}
              : lgrs_pkg::res_entry_t'{cells: evolved, done: 1'b0};
  assign e1   = '{cells: row_m, done: 1'b1};

  always_comb begin
    push.cnt    = accept ? (2'(e0_v) + 2'(e1_v)) : 2'd0;
    push.first  = e0_v ? e0 : e1;
    push.second = e1;
  end

  lgrs_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .head_o  (head)
  );

  assign row_ready_o      = room;
  assign next_row_cells_o = head.cells;
  assign frame_done_o     = head.done;

  // checks
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("rows seen count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_last_row_i) |=> (seen_q == 2'd0))
    else $error("last row did not restart the frame");

  a_second_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_last_row_i && (seen_q != 2'd0)) |=> (seen_q == 2'd2))
    else $error("row store not full after second row");

  a_first_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (seen_q == 2'd0)) |=> res_valid_o)
    else $error("first row of frame produced no result");

endmodule

>>> sim/tb_life_generation_row_stream.sv
// Self-checking testbench for the Game of Life row stream, with its scoreboard.
`timescale 1ns / 100ps

module tb_life_generation_row_stream;

  // Cycles in which no item moves on either channel before the run is abandoned.
  localparam int unsigned IdleLimit = 1000;
  // Random rows per column setting; seven settings give at least 406 rows.
  localparam int unsigned RowsPerPhase = 58;
  localparam int unsigned NumPhases = 7;

  // One expected next-generation row.
  typedef struct {
    logic [lgrs_pkg::MaxCols-1:0] cells;
    logic                         done;
  } gen_row_t;

  // Kinds of random row content.
  typedef enum int {
    ROW_RANDOM,
    ROW_SPARSE,
    ROW_SPARSER,
    ROW_DENSE,
    ROW_EMPTY,
    ROW_FULL
  } row_kind_e;

  // Scoreboard: own copy of the row store and width, queue of expected rows.
  class life_scoreboard;
    logic [lgrs_pkg::ColW-1:0]    cols = lgrs_pkg::ColsReset;
    logic [lgrs_pkg::MaxCols-1:0] above_row = '0;
    logic [lgrs_pkg::MaxCols-1:0] centre_row = '0;
    int unsigned                  rows_held = 0;
    gen_row_t                     pending_rows[$];
    int unsigned                  errors = 0;
    int unsigned                  results_seen = 0;

    function int unsigned active_cols();
      return (cols > lgrs_pkg::ColW'(lgrs_pkg::MaxCols)) ? lgrs_pkg::MaxCols : int'(cols);
    endfunction

    function logic [lgrs_pkg::MaxCols-1:0] col_mask(int unsigned n);
      logic [lgrs_pkg::MaxCols-1:0] m;
      m = '0;
      for (int unsigned j = 0; j < n; j++) m[j] = 1'b1;
      return m;
    endfunction

    // B3/S23 on the interior columns; edges and short rows pass through.
    function logic [lgrs_pkg::MaxCols-1:0] next_gen(logic [lgrs_pkg::MaxCols-1:0] up,
                                                    logic [lgrs_pkg::MaxCols-1:0] mid,
                                                    logic [lgrs_pkg::MaxCols-1:0] down,
                                                    int unsigned n);
      logic [lgrs_pkg::MaxCols-1:0] res;
      int unsigned                  cnt;
      res = mid & col_mask(n);
      if (n < 3) return res;
      for (int unsigned j = 1; j + 1 < n; j++) begin
        cnt = int'(up[j-1]) + int'(up[j]) + int'(up[j+1])
            + int'(mid[j-1]) + int'(mid[j+1])
            + int'(down[j-1]) + int'(down[j]) + int'(down[j+1]);
        res[j] = (cnt == 3) || (mid[j] && cnt == 2);
      end
      return res;
    endfunction

    function void push_row(logic [lgrs_pkg::MaxCols-1:0] cells, logic done);
      gen_row_t e;
      e.cells = cells;
      e.done  = done;
      pending_rows.push_back(e);
    endfunction

    function void clear_store();
      above_row  = '0;
      centre_row = '0;
      rows_held  = 0;
    endfunction

    // An input row has been taken: work out the rows it releases.
    function void note_row(logic [lgrs_pkg::MaxCols-1:0] cells, logic last);
      int unsigned                  n;
      logic [lgrs_pkg::MaxCols-1:0] row;
      n   = active_cols();
      row = cells & col_mask(n);
      if (rows_held == 0) begin
        push_row(row, last);
        if (last) begin
          clear_store();
        end else begin
          centre_row = row;
          rows_held  = 1;
        end
        return;
      end
      if (rows_held >= 2) begin
        push_row(next_gen(above_row, centre_row, row, n) & col_mask(n), 1'b0);
      end
      if (last) begin
        push_row(row, 1'b1);
        clear_store();
      end else begin
        above_row  = centre_row;
        centre_row = row;
        rows_held  = 2;
      end
    endfunction

    // A result has been taken: compare it with the oldest expectation.
    function void check_row(logic [lgrs_pkg::MaxCols-1:0] cells, logic done);
      gen_row_t e;
      results_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cells %h done %b",
                 $time, cells, done);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      if (cells !== e.cells) begin
        $display("%0t: next_row_cells mismatch, expected %h, actual %h",
                 $time, e.cells, cells);
        errors++;
      end
      if (done !== e.done) begin
        $display("%0t: frame_done mismatch, expected %b, actual %b", $time, e.done, done);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_rows.size();
    endfunction
  endclass

  // Block ports; every input has a known value from time zero.
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [lgrs_pkg::ColW-1:0]     cfg_wdata_i = '0;
  logic                          row_valid_i = 1'b0;
  logic                          row_ready_o;
  logic [lgrs_pkg::MaxCols-1:0]  row_cells_i = '0;
  logic                          is_last_row_i = 1'b0;
  logic                          res_valid_o;
  logic                          res_ready_i = 1'b1;
  logic [lgrs_pkg::MaxCols-1:0]  next_row_cells_o;
  logic                          frame_done_o;

  life_scoreboard sb = new;

  // With calm set, neither side idles: used for the closing stretch.
  bit          calm = 1'b0;
  int unsigned rows_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;

  life_generation_row_stream i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .row_valid_i      (row_valid_i),
    .row_ready_o      (row_ready_o),
    .row_cells_i      (row_cells_i),
    .is_last_row_i    (is_last_row_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .next_row_cells_o (next_row_cells_o),
    .frame_done_o     (frame_done_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sample both channels at the edge. Results are checked before the input is
  // noted, since a result can never stem from a row taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) sb.check_row(next_row_cells_o, frame_done_o);
      if (row_valid_i && row_ready_o) sb.note_row(row_cells_i, is_last_row_i);
    end
  end

  // Watchdog: too long without any item moving means the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((row_valid_i && row_ready_o) || (res_valid_o && res_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == IdleLimit) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, IdleLimit, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: ready drops at random for random stretches, except when calm.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        res_ready_i <= 1'b1;
      end
    end
  end

  // Offer one row and return at the edge where it is taken. A random gap
  // before it drops valid first; back-to-back rows keep valid high.
  task automatic send_row(input logic [lgrs_pkg::MaxCols-1:0] cells, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      row_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    row_valid_i   <= 1'b1;
    row_cells_i   <= cells;
    is_last_row_i <= last;
    @(posedge clk_i);
    while (!row_ready_o) @(posedge clk_i);
    rows_sent++;
    if (last) frames_sent++;
  endtask

  // Stop offering rows until every expected result is back, then settle.
  task automatic wait_drained(input int unsigned settle);
    row_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Width is only changed with the block idle.
  task automatic set_cols(input logic [lgrs_pkg::ColW-1:0] value);
    wait_drained(3);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.cols = value;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [lgrs_pkg::MaxCols-1:0] rand_row(row_kind_e kind);
    logic [lgrs_pkg::MaxCols-1:0] a;
    logic [lgrs_pkg::MaxCols-1:0] b;
    logic [lgrs_pkg::MaxCols-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (kind)
      ROW_SPARSE:  return a & b;
      ROW_SPARSER: return a & b & c;
      ROW_DENSE:   return a | b;
      ROW_EMPTY:   return '0;
      ROW_FULL:    return '1;
      default:     return a;
    endcase
  endfunction

  // Plain random, sparse and dense rows so that births and
  // survivals both show up, and the odd empty or full row.
  function automatic row_kind_e pick_kind();
    case ($urandom_range(0, 9))
      0, 1, 2: return ROW_RANDOM;
      3, 4:    return ROW_SPARSE;
      5:       return ROW_SPARSER;
      6, 7:    return ROW_DENSE;
      8:       return ROW_EMPTY;
      default: return ROW_FULL;
    endcase
  endfunction

  // A frame of random rows; hold_at, when below len, pauses the sender
  // mid-frame until every expected result has come out.
  task automatic send_frame(input int unsigned len, input int unsigned hold_at);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == hold_at) wait_drained(0);
      send_row(rand_row(pick_kind()), i == len - 1);
    end
  endtask

  task automatic send_full_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_row('1, i == len - 1);
  endtask

  initial begin
    int unsigned                phase_rows;
    int unsigned                len;
    logic [lgrs_pkg::ColW-1:0]  width;
    bit                         held;

    held = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full width from reset.
    send_row('1, 1'b1);                           // one-row frame
    send_row({32{2'b10}}, 1'b0);                  // two-row frame, both border
    send_row({32{2'b01}}, 1'b1);
    send_row('0, 1'b0);                           // vertical blinker turns flat
    send_row(64'h1 << 5, 1'b0);
    send_row(64'h1 << 5, 1'b0);
    send_row(64'h1 << 5, 1'b0);
    send_row('0, 1'b1);
    send_full_frame(3);                           // crowded interior dies
    send_row(64'h8000_0000_0000_0001, 1'b0);      // edge columns only
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    set_cols(7'd127);                             // above the maximum, acts as 64
    send_frame(3, 3);
    set_cols(7'd0);                               // no active columns
    send_full_frame(3);
    set_cols(7'd2);                               // all border
    send_full_frame(3);
    set_cols(7'd3);                               // a single interior column
    send_full_frame(3);
    set_cols(7'd10);                              // bits above the width ignored
    send_full_frame(3);

    // Random: one width per phase, the last phase full width with no idling.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       width = 7'd64;
        1:       width = 7'($urandom_range(3, 63));
        2:       width = 7'($urandom_range(65, 127));
        3:       width = 7'($urandom_range(3, 8));
        4:       width = 7'($urandom_range(0, 2));
        5:       width = 7'($urandom_range(1, 127));
        default: width = 7'd64;
      endcase
      set_cols(width);
      if (p == NumPhases - 1) calm = 1'b1;
      phase_rows = 0;
      while (phase_rows < RowsPerPhase) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = 2;
          default: len = $urandom_range(3, 12);
        endcase
        if (!held && p == 1 && len >= 4) begin
          send_frame(len, 2);
          held = 1'b1;
        end else begin
          send_frame(len, len);
        end
        phase_rows += len;
      end
    end

    // Let the queue empty, then settle to catch anything stray.
    wait_drained(8);

    $display("Covered %0d rows in %0d frames over %0d width settings, %0d results checked.",
             rows_sent, frames_sent, cfg_writes, sb.results_seen);
    $display("Widths from zero to above the maximum, with stalls on both sides.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
